### rtl/tia_pkg.sv
// shared constants, codes and controller/datapath structs for the
// transportation initial allocation block; no dependencies
package tia_pkg;

    // problem size and value width
    localparam int ROWS       = 8;
    localparam int COLS       = 8;
    localparam int VALUE_BITS = 16;

    localparam int ROW_BITS    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_BITS    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CELLS       = ROWS * COLS;
    localparam int ADDR_BITS   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int AMOUNT_BITS = VALUE_BITS - 1;
    localparam int PROD_BITS   = 2 * AMOUNT_BITS;
    localparam int DIFF_BITS   = VALUE_BITS + 2;
    localparam int SSUM_BITS   = VALUE_BITS + 5;
    localparam int SUM_BITS    = 34;
    localparam int TOTAL_BITS  = 33;
    localparam int MAX_RES     = ROWS + COLS - 1;
    localparam int N_BITS      = $clog2(ROWS + COLS);

    // input commands
    localparam logic [1:0] CMD_LOAD_COST   = 2'd0;
    localparam logic [1:0] CMD_LOAD_SUPPLY = 2'd1;
    localparam logic [1:0] CMD_LOAD_DEMAND = 2'd2;
    localparam logic [1:0] CMD_START       = 2'd3;

    // result status
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NEG   = 2'd1;
    localparam logic [1:0] STATUS_UNBAL = 2'd2;

    // what the datapath does with a cell read back from the cost memory
    localparam logic [1:0] MODE_CHECK = 2'd0;
    localparam logic [1:0] MODE_MAX   = 2'd1;
    localparam logic [1:0] MODE_SEL   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       start_check;
        logic       scan;
        logic [1:0] mode;
        logic       init_solve;
        logic       start_round;
        logic       do_alloc;
        logic       do_mul;
        logic       do_acc;
        logic       load_err;
        logic [1:0] err_code;
    } tia_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic neg;
        logic sums_eq;
        logic out_taken;
        logic out_last;
    } tia_stat_t;

endpackage

### rtl/transport_initial_allocation.sv
// top level of the transportation initial allocation block (Russell's method)
// instantiates tia_ctrl and tia_dp; depends on tia_pkg
//
//  channel | ports                                            | direction
//  s_      | s_command s_row s_col s_value, s_valid/s_ready   | load and start beats in
//  m_      | m_status m_alloc_row m_alloc_col m_amount        | allocation beats out
//          | m_total_cost m_last, m_valid/m_ready             |
//
// a load beat is taken while idle; start runs a check pass over every cell,
// then each allocation round runs its scan passes, its alloc, multiply and
// accumulate steps and then its result beat; the cost memory has one read port
// the solver walks every cell once for the maxima and once for the selection
// s_ready is high only while idle; a stalled result beat holds the solver
// synchronous active-low reset returns to idle with all lines open
module transport_initial_allocation (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_command,
    input  logic [tia_pkg::ROW_BITS-1:0]          s_row,
    input  logic [tia_pkg::COL_BITS-1:0]          s_col,
    input  logic signed [tia_pkg::VALUE_BITS-1:0] s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic [tia_pkg::ROW_BITS-1:0]          m_alloc_row,
    output logic [tia_pkg::COL_BITS-1:0]          m_alloc_col,
    output logic [tia_pkg::AMOUNT_BITS-1:0]       m_amount,
    output logic [tia_pkg::TOTAL_BITS-1:0]        m_total_cost,
    output logic                                  m_last
);

    tia_pkg::tia_cmd_t  cmd;
    tia_pkg::tia_stat_t stat;

    // sequencer
    tia_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and arithmetic
    tia_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_command    (s_command),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_alloc_row  (m_alloc_row),
        .m_alloc_col  (m_alloc_col),
        .m_amount     (m_amount),
        .m_total_cost (m_total_cost),
        .m_last       (m_last)
    );

endmodule

### rtl/tia_ctrl.sv
// controller state machine for the transportation initial allocation block
// depends on tia_pkg for command and status structs
module tia_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [1:0]          s_command,
    output logic                s_ready,
    input  tia_pkg::tia_stat_t  stat,
    output tia_pkg::tia_cmd_t   cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHK   = 4'd1;
    localparam logic [3:0] ST_CHKE  = 4'd2;
    localparam logic [3:0] ST_CHKV  = 4'd3;
    localparam logic [3:0] ST_MAXP  = 4'd4;
    localparam logic [3:0] ST_MAXE  = 4'd5;
    localparam logic [3:0] ST_SELP  = 4'd6;
    localparam logic [3:0] ST_SELE  = 4'd7;
    localparam logic [3:0] ST_ALLOC = 4'd8;
    localparam logic [3:0] ST_MUL   = 4'd9;
    localparam logic [3:0] ST_ACC   = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_command == tia_pkg::CMD_START) begin
                    cmd.start_check = 1'b1;
                    state_next      = ST_CHK;
                end
            end
            ST_CHK: begin
                cmd.scan = 1'b1;
                cmd.mode = tia_pkg::MODE_CHECK;
                if (stat.scan_last) state_next = ST_CHKE;
            end
            ST_CHKE: begin
                cmd.mode   = tia_pkg::MODE_CHECK;
                state_next = ST_CHKV;
            end
            ST_CHKV: begin
                priority if (stat.neg) begin
                    cmd.load_err = 1'b1;
                    cmd.err_code = tia_pkg::STATUS_NEG;
                    state_next   = ST_EMIT;
                end else if (!stat.sums_eq) begin
                    cmd.load_err = 1'b1;
                    cmd.err_code = tia_pkg::STATUS_UNBAL;
                    state_next   = ST_EMIT;
                end else begin
                    cmd.init_solve  = 1'b1;
                    cmd.start_round = 1'b1;
                    state_next      = ST_MAXP;
                end
            end
            ST_MAXP: begin
                cmd.scan = 1'b1;
                cmd.mode = tia_pkg::MODE_MAX;
                if (stat.scan_last) state_next = ST_MAXE;
            end
            ST_MAXE: begin
                cmd.mode   = tia_pkg::MODE_MAX;
                state_next = ST_SELP;
            end
            ST_SELP: begin
                cmd.scan = 1'b1;
                cmd.mode = tia_pkg::MODE_SEL;
                if (stat.scan_last) state_next = ST_SELE;
            end
            ST_SELE: begin
                cmd.mode   = tia_pkg::MODE_SEL;
                state_next = ST_ALLOC;
            end
            ST_ALLOC: begin
                cmd.do_alloc = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.do_mul = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.do_acc = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_taken) begin
                    if (stat.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.start_round = 1'b1;
                        state_next      = ST_MAXP;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/tia_dp.sv
// datapath: cost memory, supply/demand stores, line maxima, cell selection,
// allocation arithmetic and result register; depends on tia_pkg
module tia_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  tia_pkg::tia_cmd_t                     cmd,
    output tia_pkg::tia_stat_t                    stat,
    input  logic [1:0]                            s_command,
    input  logic [tia_pkg::ROW_BITS-1:0]          s_row,
    input  logic [tia_pkg::COL_BITS-1:0]          s_col,
    input  logic signed [tia_pkg::VALUE_BITS-1:0] s_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic [tia_pkg::ROW_BITS-1:0]          m_alloc_row,
    output logic [tia_pkg::COL_BITS-1:0]          m_alloc_col,
    output logic [tia_pkg::AMOUNT_BITS-1:0]       m_amount,
    output logic [tia_pkg::TOTAL_BITS-1:0]        m_total_cost,
    output logic                                  m_last
);

    localparam int RB = tia_pkg::ROW_BITS;
    localparam int CB = tia_pkg::COL_BITS;
    localparam int VB = tia_pkg::VALUE_BITS;

    // stores
    logic signed [VB-1:0] cost_mem   [tia_pkg::CELLS];
    logic signed [VB-1:0] supply_reg [tia_pkg::ROWS];
    logic signed [VB-1:0] demand_reg [tia_pkg::COLS];
    logic signed [VB-1:0] u_reg      [tia_pkg::ROWS];
    logic signed [VB-1:0] v_reg      [tia_pkg::COLS];

    // scan and pipeline registers
    logic [RB-1:0]        ri_reg, pi_reg;
    logic [CB-1:0]        ci_reg, pj_reg;
    logic                 pv_reg;
    logic signed [VB-1:0] rd_data_reg;

    // check, solve and result registers
    logic                                 neg_reg;
    logic signed [tia_pkg::SSUM_BITS-1:0] ssum_reg, dsum_reg;
    logic [tia_pkg::ROWS-1:0]             row_open_reg;
    logic [tia_pkg::COLS-1:0]             col_open_reg;
    logic [tia_pkg::N_BITS-1:0]           n_reg;
    logic                                 found_reg;
    logic signed [tia_pkg::DIFF_BITS-1:0] best_d_reg;
    logic signed [VB-1:0]                 best_c_reg;
    logic [RB-1:0]                        bi_reg;
    logic [CB-1:0]                        bj_reg;
    logic [tia_pkg::AMOUNT_BITS-1:0]      amt_reg;
    logic [tia_pkg::PROD_BITS-1:0]        prod_reg;
    logic [tia_pkg::SUM_BITS-1:0]         cost_sum_reg;
    logic                                 m_valid_reg;
    logic [1:0]                           m_status_reg;
    logic [RB-1:0]                        m_row_reg;
    logic [CB-1:0]                        m_col_reg;
    logic [tia_pkg::AMOUNT_BITS-1:0]      m_amount_reg;
    logic [tia_pkg::TOTAL_BITS-1:0]       m_total_reg;
    logic                                 m_last_reg;

    // combinational helpers
    logic                                 row_ok, col_ok;
    logic [tia_pkg::ADDR_BITS-1:0]        wr_addr, rd_addr;
    logic                                 scan_last;
    logic [RB-1:0]                        sel_row;
    logic [CB-1:0]                        sel_col;
    logic signed [VB-1:0]                 sup_rd, dem_rd, amt_min;
    logic signed [VB-1:0]                 u_cur, v_cur;
    logic                                 cell_open;
    logic signed [tia_pkg::DIFF_BITS-1:0] diff;
    logic                                 better;
    logic [tia_pkg::SUM_BITS-1:0]         sum_next;
    logic [tia_pkg::ROWS-1:0]             row_open_next;
    logic [tia_pkg::COLS-1:0]             col_open_next;
    logic                                 last_next;

    // load address decode
    assign row_ok  = {1'b0, s_row} < (RB + 1)'(tia_pkg::ROWS);
    assign col_ok  = {1'b0, s_col} < (CB + 1)'(tia_pkg::COLS);
    assign wr_addr = tia_pkg::ADDR_BITS'(int'(s_row) * tia_pkg::COLS + int'(s_col));
    assign rd_addr = tia_pkg::ADDR_BITS'(int'(ri_reg) * tia_pkg::COLS + int'(ci_reg));
    assign scan_last = (ri_reg == RB'(tia_pkg::ROWS - 1)) && (ci_reg == CB'(tia_pkg::COLS - 1));

    // one read index into supply and demand
    assign sel_row = (cmd.mode == tia_pkg::MODE_CHECK && pv_reg) ? pi_reg : bi_reg;
    assign sel_col = (cmd.mode == tia_pkg::MODE_CHECK && pv_reg) ? pj_reg : bj_reg;
    assign sup_rd  = supply_reg[sel_row];
    assign dem_rd  = demand_reg[sel_col];
    assign amt_min = (sup_rd < dem_rd) ? sup_rd : dem_rd;

    // cell score for the selection pass
    assign u_cur     = u_reg[pi_reg];
    assign v_cur     = v_reg[pj_reg];
    assign cell_open = row_open_reg[pi_reg] & col_open_reg[pj_reg];
    assign diff      = tia_pkg::DIFF_BITS'(rd_data_reg) - tia_pkg::DIFF_BITS'(u_cur)
                     - tia_pkg::DIFF_BITS'(v_cur);
    assign better    = !found_reg || (diff < best_d_reg)
                     || (diff == best_d_reg && rd_data_reg < best_c_reg);

    // allocation bookkeeping, supply/demand already reduced
    assign sum_next      = cost_sum_reg + tia_pkg::SUM_BITS'(prod_reg);
    assign row_open_next = row_open_reg & ~(tia_pkg::ROWS'(sup_rd == '0) << bi_reg);
    assign col_open_next = col_open_reg & ~(tia_pkg::COLS'(dem_rd == '0) << bj_reg);
    assign last_next     = (n_reg == tia_pkg::N_BITS'(tia_pkg::MAX_RES - 1))
                         || (row_open_next == '0) || (col_open_next == '0);

    // cost memory
    always_ff @(posedge aclk) begin
        if (cmd.load && s_command == tia_pkg::CMD_LOAD_COST && row_ok && col_ok) begin
            cost_mem[wr_addr] <= s_value;
        end
        rd_data_reg <= cost_mem[rd_addr];
    end

    // supply, demand and line maxima
    always_ff @(posedge aclk) begin
        if (cmd.load && s_command == tia_pkg::CMD_LOAD_SUPPLY && row_ok) begin
            supply_reg[s_row] <= s_value;
        end
        if (cmd.load && s_command == tia_pkg::CMD_LOAD_DEMAND && col_ok) begin
            demand_reg[s_col] <= s_value;
        end
        if (cmd.do_mul) begin
            supply_reg[bi_reg] <= sup_rd - $signed({1'b0, amt_reg});
            demand_reg[bj_reg] <= dem_rd - $signed({1'b0, amt_reg});
        end
        if (cmd.start_round) begin
            for (int k = 0; k < tia_pkg::ROWS; k++) u_reg[k] <= '0;
            for (int k = 0; k < tia_pkg::COLS; k++) v_reg[k] <= '0;
        end else if (pv_reg && cmd.mode == tia_pkg::MODE_MAX && cell_open) begin
            if (rd_data_reg > u_cur) u_reg[pi_reg] <= rd_data_reg;
            if (rd_data_reg > v_cur) v_reg[pj_reg] <= rd_data_reg;
        end
    end

    // payload registers of the solve
    always_ff @(posedge aclk) begin
        if (cmd.start_check) begin
            ssum_reg <= '0;
            dsum_reg <= '0;
        end else if (pv_reg && cmd.mode == tia_pkg::MODE_CHECK) begin
            if (pj_reg == '0) ssum_reg <= ssum_reg + tia_pkg::SSUM_BITS'(sup_rd);
            if (pi_reg == '0) dsum_reg <= dsum_reg + tia_pkg::SSUM_BITS'(dem_rd);
        end
        if (pv_reg && cmd.mode == tia_pkg::MODE_SEL && cell_open && better) begin
            best_d_reg <= diff;
            best_c_reg <= rd_data_reg;
            bi_reg     <= pi_reg;
            bj_reg     <= pj_reg;
        end
        if (cmd.do_alloc) amt_reg <= amt_min[tia_pkg::AMOUNT_BITS-1:0];
        if (cmd.do_mul) prod_reg <= amt_reg * best_c_reg[tia_pkg::AMOUNT_BITS-1:0];
        if (cmd.load_err) begin
            m_status_reg <= cmd.err_code;
            m_row_reg    <= '0;
            m_col_reg    <= '0;
            m_amount_reg <= '0;
            m_total_reg  <= '0;
            m_last_reg   <= 1'b1;
        end else if (cmd.do_acc) begin
            m_status_reg <= tia_pkg::STATUS_OK;
            m_row_reg    <= bi_reg;
            m_col_reg    <= bj_reg;
            m_amount_reg <= amt_reg;
            m_total_reg  <= sum_next[tia_pkg::TOTAL_BITS-1:0];
            m_last_reg   <= last_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ri_reg       <= '0;
            ci_reg       <= '0;
            pi_reg       <= '0;
            pj_reg       <= '0;
            pv_reg       <= 1'b0;
            neg_reg      <= 1'b0;
            row_open_reg <= '1;
            col_open_reg <= '1;
            n_reg        <= '0;
            found_reg    <= 1'b0;
            cost_sum_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // cell scan, row-major, one memory read a cycle
            pv_reg <= cmd.scan;
            pi_reg <= ri_reg;
            pj_reg <= ci_reg;
            if (cmd.scan) begin
                if (ci_reg == CB'(tia_pkg::COLS - 1)) begin
                    ci_reg <= '0;
                    ri_reg <= scan_last ? '0 : ri_reg + 1'b1;
                end else begin
                    ci_reg <= ci_reg + 1'b1;
                end
            end
            // negative value search
            if (cmd.start_check) begin
                neg_reg <= 1'b0;
            end else if (pv_reg && cmd.mode == tia_pkg::MODE_CHECK) begin
                if (rd_data_reg < 0) neg_reg <= 1'b1;
                if (pj_reg == '0 && sup_rd < 0) neg_reg <= 1'b1;
                if (pi_reg == '0 && dem_rd < 0) neg_reg <= 1'b1;
            end
            // open lines, round count and running cost
            if (cmd.init_solve) begin
                row_open_reg <= '1;
                col_open_reg <= '1;
                n_reg        <= '0;
                cost_sum_reg <= '0;
            end else if (cmd.do_acc) begin
                row_open_reg <= row_open_next;
                col_open_reg <= col_open_next;
                n_reg        <= n_reg + 1'b1;
                cost_sum_reg <= sum_next;
            end
            if (cmd.start_round) begin
                found_reg <= 1'b0;
            end else if (pv_reg && cmd.mode == tia_pkg::MODE_SEL && cell_open) begin
                found_reg <= 1'b1;
            end
            // result beat
            if (cmd.load_err || cmd.do_acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.scan_last = scan_last;
    assign stat.neg       = neg_reg;
    assign stat.sums_eq   = (ssum_reg == dsum_reg);
    assign stat.out_taken = m_valid_reg & m_ready;
    assign stat.out_last  = m_last_reg;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_alloc_row  = m_row_reg;
    assign m_alloc_col  = m_col_reg;
    assign m_amount     = m_amount_reg;
    assign m_total_cost = m_total_reg;
    assign m_last       = m_last_reg;

    // scan counters rest at the first cell between passes
    a_scan_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.scan |-> (ri_reg == '0 && ci_reg == '0))
        else $error("scan counters not at first cell");

    // rows never reopen except at the start of a solve
    a_rows_close: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.init_solve) |-> ((row_open_reg & ~$past(row_open_reg)) == '0))
        else $error("closed row reopened");

    // round count bounded by ROWS+COLS-1, one fewer than the number of lines
    a_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= tia_pkg::N_BITS'(tia_pkg::MAX_RES))
        else $error("too many allocation rounds");

    // an error beat is always the final one
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_err |=> (m_valid_reg && m_last_reg))
        else $error("error result not marked last");

endmodule
